// ----- rtl/tcw_pkg.sv -----
// text console writer: shared types and constants
// beat structs, item kinds and default console geometry; no dependencies
`default_nettype none

package tcw_pkg;

    localparam int          ROWS_DEF     = 10;
    localparam int          COLS_DEF     = 25;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        KIND_PUT      = 2'd0,
        KIND_LINE_END = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_READ     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [3:0] read_row;
        logic [4:0] read_col;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] cursor_row;
        logic [4:0] cursor_col;
        logic [1:0] scroll_count;
        logic [7:0] read_char;
    } t_out_beat;

    typedef struct packed {
        logic [3:0] cursor_row;
        logic [4:0] cursor_col;
        logic [1:0] scroll_count;
        logic       use_fill;
        logic       hit;
    } t_step_info;

endpackage

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// text console writer: generic single-write, single-read ram
// registered read with read enable; no dependencies
`default_nettype none

module tcw_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_cursor.sv -----
// text console writer: cursor, scroll offset and store address generation
// uses tcw_pkg; drives the cell and row-fill rams in the top level
`default_nettype none

module tcw_cursor import tcw_pkg::*; #(
    parameter  int ROWS = ROWS_DEF,
    parameter  int COLS = COLS_DEF,
    localparam int RW   = $clog2(ROWS),
    localparam int CW   = $clog2(COLS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire t_in_beat      i_item,
    output logic               o_cell_we,
    output logic [RW+CW-1:0]   o_cell_waddr,
    output logic [7:0]         o_cell_wdata,
    output logic [RW+CW-1:0]   o_cell_raddr,
    output logic               o_fill_we,
    output logic [RW-1:0]      o_fill_waddr,
    output logic [CW-1:0]      o_fill_wdata,
    output logic [RW-1:0]      o_fill_raddr,
    output logic [CW-1:0]      o_rd_col,
    output t_step_info         o_info
);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    logic [RW-1:0] r_row, n_row;
    logic [RW-1:0] r_phys, n_phys;
    logic [RW-1:0] r_off, n_off;
    logic [CW-1:0] r_col, n_col;

    logic          is_put, is_char, is_read, wrap, adv2, scr1, scr2, in_range;
    logic [RW-1:0] row1, phys1, off1, rd_phys;
    logic [CW-1:0] col1, rd_col;
    logic [31:0]   rd_sum;

    function automatic logic [RW-1:0] inc_row(input logic [RW-1:0] x);
        return (x == LAST_ROW) ? '0 : x + 1'b1;
    endfunction

    // wrap advance, then newline advance; entered row is always the next physical row; clear resets all
    always_comb begin
        is_put  = (i_item.kind == KIND_PUT);
        is_read = (i_item.kind == KIND_READ);
        is_char = is_put && (i_item.char_code != NEWLINE_CODE);
        wrap    = is_put && (r_col == LAST_COL);
        adv2    = (is_put && !is_char) || (i_item.kind == KIND_LINE_END);

        scr1  = wrap && (r_row == LAST_ROW);
        row1  = (wrap && !scr1) ? r_row + 1'b1 : r_row;
        phys1 = wrap ? inc_row(r_phys) : r_phys;
        off1  = scr1 ? inc_row(r_off) : r_off;
        col1  = wrap ? '0 : r_col;

        scr2   = adv2 && (row1 == LAST_ROW);
        n_row  = (adv2 && !scr2) ? row1 + 1'b1 : row1;
        n_phys = adv2 ? inc_row(phys1) : phys1;
        n_off  = scr2 ? inc_row(off1) : off1;
        n_col  = adv2 ? '0 : (is_char ? col1 + 1'b1 : col1);

        case (i_item.kind)
            KIND_CLEAR: begin
                n_row  = '0;
                n_phys = '0;
                n_off  = '0;
                n_col  = '0;
            end
            default: begin
            end
        endcase
    end

    // logical read row to physical row
    always_comb begin
        rd_sum   = 32'(r_off) + 32'(i_item.read_row);
        rd_phys  = RW'((rd_sum >= 32'(ROWS)) ? rd_sum - 32'(ROWS) : rd_sum);
        rd_col   = CW'(32'(i_item.read_col));
        in_range = (32'(i_item.read_row) < 32'(ROWS)) && (32'(i_item.read_col) < 32'(COLS));
    end

    always_comb begin
        o_cell_we    = i_en && is_char;
        o_cell_waddr = {phys1, col1};
        o_cell_wdata = i_item.char_code;
        o_cell_raddr = {rd_phys, rd_col};
        o_fill_we    = i_en && (is_put || (i_item.kind == KIND_LINE_END));
        o_fill_waddr = phys1;
        o_fill_wdata = is_char ? col1 + 1'b1 : col1;
        o_fill_raddr = rd_phys;
        o_rd_col     = rd_col;

        o_info.cursor_row   = 4'(32'(n_row));
        o_info.cursor_col   = 5'(32'(n_col));
        o_info.scroll_count = {1'b0, scr1} + {1'b0, scr2};
        o_info.use_fill     = is_read && in_range && (32'(i_item.read_row) < 32'(r_row));
        o_info.hit          = is_read && in_range && (32'(i_item.read_row) == 32'(r_row))
                              && (rd_col < r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_phys <= '0;
            r_off  <= '0;
            r_col  <= '0;
        end else if (i_en) begin
            r_row  <= n_row;
            r_phys <= n_phys;
            r_off  <= n_off;
            r_col  <= n_col;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_writer_top.sv -----
// an accepted input beat is held in the input register, then its result beat in the output register
// throughput: one item per cycle for every kind; stall only from output back-pressure
// scroll moves a row offset; per-row fill lengths in a small ram mask stale cells
// reset clears the cursor, offset and valid flags; no clearing pass
// uses tcw_pkg, tcw_cursor and tcw_ram
`default_nettype none

module text_console_writer_top import tcw_pkg::*; #(
    parameter  int ROWS = ROWS_DEF,
    parameter  int COLS = COLS_DEF,
    localparam int RW   = $clog2(ROWS),
    localparam int CW   = $clog2(COLS)
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    logic       r_in_v, r_out_v, adv;
    t_in_beat   r_in;
    t_step_info info, r_info;
    logic [CW-1:0] rd_col, r_rd_col;

    logic             cell_we;
    logic [RW+CW-1:0] cell_waddr, cell_raddr;
    logic [7:0]       cell_wdata, cell_rdata;
    logic             fill_we;
    logic [RW-1:0]    fill_waddr, fill_raddr;
    logic [CW-1:0]    fill_wdata, fill_rdata;

    assign adv        = r_in_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_in_v && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    tcw_cursor #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_cursor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_item       (r_in),
        .o_cell_we    (cell_we),
        .o_cell_waddr (cell_waddr),
        .o_cell_wdata (cell_wdata),
        .o_cell_raddr (cell_raddr),
        .o_fill_we    (fill_we),
        .o_fill_waddr (fill_waddr),
        .o_fill_wdata (fill_wdata),
        .o_fill_raddr (fill_raddr),
        .o_rd_col     (rd_col),
        .o_info       (info)
    );

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (ROWS * (2 ** CW))
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_re    (adv),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    // number of written cells in each physical row
    tcw_ram #(
        .WIDTH (CW),
        .DEPTH (ROWS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (adv),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_info   <= info;
            r_rd_col <= rd_col;
        end
    end

    always_comb begin
        o_out_valid             = r_out_v;
        o_out_data.cursor_row   = r_info.cursor_row;
        o_out_data.cursor_col   = r_info.cursor_col;
        o_out_data.scroll_count = r_info.scroll_count;
        o_out_data.read_char    = ((r_info.use_fill && (r_rd_col < fill_rdata)) || r_info.hit)
                                  ? cell_rdata : 8'd0;
    end

`ifndef SYNTHESIS
    a_stall_only_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_v && i_out_stall))
        else $error("input stalled without output back-pressure");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_v)
        else $error("processed item did not reach output stage");

    a_scroll_at_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_info.scroll_count != 2'd0))
        |-> (r_info.cursor_row == 4'(ROWS - 1)))
        else $error("scroll reported with cursor off the bottom row");

    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_info.use_fill && r_info.hit))
        else $error("read selects both fill and cursor row");
`endif

endmodule

`default_nettype wire
